FILE: src/gccc_pkg.sv
// Shared types, constants and functions for the grid coast cell counter.
`default_nettype none

package gccc_pkg;

    localparam int CFG_W   = 11;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 21;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = 11'd1024;

    localparam logic [CHAR_W-1:0] CHAR_LAND  = 8'd35;
    localparam logic [CHAR_W-1:0] CHAR_WATER = 8'd46;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [0:0] {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        CLS_NEITHER = 2'd0,
        CLS_LAND    = 2'd1,
        CLS_WATER   = 2'd2
    } cls_t;

    function automatic cls_t classify(input logic [CHAR_W-1:0] ch);
        cls_t c;
        if (ch == CHAR_LAND)
        begin
            c = CLS_LAND;
        end
        else if (ch == CHAR_WATER)
        begin
            c = CLS_WATER;
        end
        else
        begin
            c = CLS_NEITHER;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/gccc_if.sv
// Valid/ready stream interfaces for map cells and coast counts.
`default_nettype none

interface gccc_cell_if
    import gccc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;

    modport source (output valid, output cell_char, input ready);
    modport sink   (input valid, input cell_char, output ready);
endinterface

interface gccc_count_if
    import gccc_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] coast_count;

    modport source (output valid, output coast_count, input ready);
    modport sink   (input valid, input coast_count, output ready);
endinterface

`default_nettype wire

FILE: src/grid_coast_cell_counter_top.sv
// Grid coast cell counter: counts land cells that touch water or the map border.
//
// Map cells arrive in raster order on cell_in, one character per transfer.
// A land cell counts as coast when one of its four neighbours is water or
// lies outside the map. map_width and map_height are set through the write
// port (cfg_we, cfg_index, cfg_data); zero acts as one, oversize as the
// maximum. On the transfer of the final cell of a map the total is registered
// onto count_out, and the count and position restart.
// A new cell can be taken every cycle. A cell of the last row is decided on
// arrival; any other is decided one transfer after the cell below it arrives,
// or with that cell at the end of a row. The line buffers are read into
// registers at the column of the next transfer, so they never stall the stream.
// If count_out is stalled, cell_in stays ready except at the final cell of
// a map, which waits until the previous total has been taken.
// Reset clears the position, the count, the output valid and the size
// registers (both 1024); line buffer contents are undefined until written.
`default_nettype none

module grid_coast_cell_counter_top
    import gccc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    gccc_cell_if.sink             cell_in,
    gccc_count_if.source          count_out
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int LWC   = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
    localparam int LWR   = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

    logic [CFG_W-1:0]   map_width_reg;
    logic [CFG_W-1:0]   map_height_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [COUNT_W-1:0] count_reg;
    cls_t               left_reg;
    logic               pend_reg;
    logic               pend_coast_reg;
    cls_t               mid_rd_reg;
    cls_t               up_rd_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;

    cls_t mid_mem [MAX_WIDTH];
    cls_t up_mem  [MAX_WIDTH];

    logic [LWC-1:0]   wm1;
    logic [LWR-1:0]   hm1;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row_idx;
    logic             row_end;
    logic             last_row;
    logic             map_end;
    logic             accept;
    logic             in_ready;
    cls_t             cur;
    logic             row_nonzero;
    logic             hit_pend;
    logic             hit_above;
    logic             hit_bottom;
    logic [1:0]       inc;
    logic [COUNT_W:0] sum;
    logic [COUNT_W-1:0] sat_count;

    assign wm1 = LWC'(map_width_reg) - LWC'(1);
    assign hm1 = LWR'(map_height_reg) - LWR'(1);

    always_comb
    begin
        if (map_width_reg == '0)
        begin
            last_col = '0;
        end
        else if (LWC'(map_width_reg) > LWC'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = wm1[COL_W-1:0];
        end

        if (map_height_reg == '0)
        begin
            last_row_idx = '0;
        end
        else if (LWR'(map_height_reg) > LWR'(MAX_HEIGHT))
        begin
            last_row_idx = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            last_row_idx = hm1[ROW_W-1:0];
        end
    end

    assign row_end  = (col_reg >= last_col);
    assign last_row = (row_reg >= last_row_idx);
    assign map_end  = row_end && last_row;

    assign in_ready      = !map_end || !out_valid_reg || count_out.ready;
    assign cell_in.ready = in_ready;
    assign accept        = cell_in.valid && in_ready;

    assign cur         = classify(cell_in.cell_char);
    assign row_nonzero = (row_reg != '0);

    // The pending cell is the one above the previous transfer; its right
    // neighbour is the old middle-row class at the current column.
    assign hit_pend   = pend_reg && (pend_coast_reg || (mid_rd_reg == CLS_WATER));
    assign hit_above  = row_nonzero && row_end && (mid_rd_reg == CLS_LAND);
    assign hit_bottom = last_row && (cur == CLS_LAND);

    assign inc = 2'({1'b0, hit_pend}) + 2'({1'b0, hit_above}) + 2'({1'b0, hit_bottom});
    assign sum = {1'b0, count_reg} + (COUNT_W + 1)'(inc);
    assign sat_count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

    always_comb
    begin
        if (accept)
        begin
            col_next = row_end ? '0 : col_reg + COL_W'(1);
        end
        else
        begin
            col_next = col_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_mem[col_reg] <= cur;
            up_mem[col_reg]  <= mid_rd_reg;
        end
        if (accept && (col_reg == col_next))
        begin
            mid_rd_reg <= cur;
            up_rd_reg  <= mid_rd_reg;
        end
        else
        begin
            mid_rd_reg <= mid_mem[col_next];
            up_rd_reg  <= up_mem[col_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_WIDTH_RST;
            map_height_reg <= MAP_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                REG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            count_reg      <= '0;
            left_reg       <= CLS_NEITHER;
            pend_reg       <= 1'b0;
            pend_coast_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && count_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                col_reg        <= col_next;
                pend_reg       <= row_nonzero && !row_end && (mid_rd_reg == CLS_LAND);
                pend_coast_reg <= (row_reg == ROW_W'(1)) || (up_rd_reg == CLS_WATER)
                                  || (cur == CLS_WATER) || (col_reg == '0)
                                  || (left_reg == CLS_WATER);
                left_reg       <= row_end ? CLS_NEITHER : mid_rd_reg;
                if (map_end)
                begin
                    row_reg       <= '0;
                    count_reg     <= '0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= sat_count;
                    if (row_end)
                    begin
                        row_reg <= row_reg + ROW_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && map_end)
        begin
            out_count_reg <= sat_count;
        end
    end

    assign count_out.valid       = out_valid_reg;
    assign count_out.coast_count = out_count_reg;

endmodule

`default_nettype wire
